// File: rtl/core/kbdtr_pkg.sv
// Shared widths, key codes and the German-layout character ROM for the
// keyboard code translator. No dependencies.
`timescale 1ns / 1ps

package kbdtr_pkg;

	localparam int CODE_W = 16;
	localparam int CHAR_W = 8;
	localparam int MOD_W  = 5;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [MOD_W-1:0]  mod_t;

	// Positions of the modifier bits.
	localparam int MOD_LSHIFT = 0;
	localparam int MOD_RSHIFT = 1;
	localparam int MOD_LCTRL  = 2;
	localparam int MOD_LALT   = 3;
	localparam int MOD_RALT   = 4;

	// Modifier press codes; the release code is the same with bit 7 set.
	localparam code_t KEY_LSHIFT = 16'h002C;
	localparam code_t KEY_RSHIFT = 16'h0039;
	localparam code_t KEY_LCTRL  = 16'h003A;
	localparam code_t KEY_LALT   = 16'h003C;
	localparam code_t KEY_RALT   = 16'h003E;
	localparam code_t KEY_RELEASE = 16'h0080;

	// Special keys.
	localparam code_t KEY_ESC    = 16'h006E;
	localparam code_t KEY_INS    = 16'h004B;
	localparam code_t KEY_DEL    = 16'h004C;
	localparam code_t KEY_ARROW_LEFT  = 16'h004F;
	localparam code_t KEY_POS1   = 16'h0050;
	localparam code_t KEY_END    = 16'h0051;
	localparam code_t KEY_ARROW_UP    = 16'h0053;
	localparam code_t KEY_ARROW_DOWN  = 16'h0054;
	localparam code_t KEY_PGUP   = 16'h0055;
	localparam code_t KEY_PGDN   = 16'h0056;
	localparam code_t KEY_ARROW_RIGHT = 16'h0059;
	localparam code_t KEY_MOUSE_L = 16'h0400;
	localparam code_t KEY_MOUSE_R = 16'h0800;

	localparam char_t CH_ESC     = 8'h1B;
	localparam char_t CH_INS     = 8'h90;
	localparam char_t CH_DEL     = 8'h91;
	localparam char_t CH_LEFT    = 8'h92;
	localparam char_t CH_HOME    = 8'h93;
	localparam char_t CH_END     = 8'h94;
	localparam char_t CH_UP      = 8'h95;
	localparam char_t CH_DOWN    = 8'h96;
	localparam char_t CH_PGUP    = 8'h97;
	localparam char_t CH_PGDN    = 8'h98;
	localparam char_t CH_RIGHT   = 8'h99;
	localparam char_t CH_MOUSE_L = 8'h9E;
	localparam char_t CH_MOUSE_R = 8'h9F;
	localparam char_t CH_NONE    = 8'h00;

	// Lower half is the plain layer, upper half the shifted layer.
	localparam char_t ROM_DE [128] = '{
		8'h00, 8'h5E, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'hDF, 8'hB4, 8'h00, 8'h08,
		8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h7A, 8'h75,
		8'h69, 8'h6F, 8'h70, 8'hFC, 8'h2B, 8'h00, 8'h00, 8'h61,
		8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C,
		8'hF6, 8'hE4, 8'h23, 8'h0D, 8'h00, 8'h3C, 8'h79, 8'h78,
		8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00,
		8'h00, 8'hB0, 8'h21, 8'h22, 8'hA7, 8'h24, 8'h25, 8'h26,
		8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h60, 8'h00, 8'h08,
		8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h5A, 8'h55,
		8'h49, 8'h4F, 8'h50, 8'hDC, 8'h2A, 8'h00, 8'h00, 8'h41,
		8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C,
		8'hD6, 8'hC4, 8'h27, 8'h0D, 8'h00, 8'h3E, 8'h59, 8'h58,
		8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00
	};

	// Symbols reached with alt held; all other keys give nothing.
	function automatic char_t alt_symbol(input logic [5:0] key);
		char_t c;
		case (key)
			6'h03: c = 8'hB2;
			6'h08: c = 8'h7B;
			6'h09: c = 8'h5B;
			6'h0A: c = 8'h5D;
			6'h0B: c = 8'h7D;
			6'h0C: c = 8'h5C;
			6'h1C: c = 8'h7E;
			6'h2D: c = 8'h7C;
			6'h34: c = 8'hB5;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/kbdtr_xlate.sv
// Combinational translation of one key code under the current modifiers,
// giving the character and the updated modifier bits. Uses kbdtr_pkg.
`timescale 1ns / 1ps

module kbdtr_xlate (
	input  kbdtr_pkg::code_t code,
	input  kbdtr_pkg::mod_t  mods,
	output kbdtr_pkg::char_t char_o,
	output kbdtr_pkg::mod_t  mods_next
);

	kbdtr_pkg::char_t rom_c;
	kbdtr_pkg::char_t plain_c;
	logic             shift_held;
	logic             letter;

	assign shift_held = mods[kbdtr_pkg::MOD_LSHIFT] | mods[kbdtr_pkg::MOD_RSHIFT];
	assign rom_c      = kbdtr_pkg::ROM_DE[{shift_held, code[5:0]}];
	assign plain_c    = kbdtr_pkg::ROM_DE[{1'b0, code[5:0]}];
	assign letter     = (plain_c >= 8'h61) && (plain_c <= 8'h7A);

	always_comb begin
		char_o    = kbdtr_pkg::CH_NONE;
		mods_next = mods;
		case (code)
			kbdtr_pkg::KEY_LSHIFT: mods_next[kbdtr_pkg::MOD_LSHIFT] = 1'b1;
			kbdtr_pkg::KEY_LSHIFT | kbdtr_pkg::KEY_RELEASE:
				mods_next[kbdtr_pkg::MOD_LSHIFT] = 1'b0;
			kbdtr_pkg::KEY_RSHIFT: mods_next[kbdtr_pkg::MOD_RSHIFT] = 1'b1;
			kbdtr_pkg::KEY_RSHIFT | kbdtr_pkg::KEY_RELEASE:
				mods_next[kbdtr_pkg::MOD_RSHIFT] = 1'b0;
			kbdtr_pkg::KEY_LCTRL: mods_next[kbdtr_pkg::MOD_LCTRL] = 1'b1;
			kbdtr_pkg::KEY_LCTRL | kbdtr_pkg::KEY_RELEASE:
				mods_next[kbdtr_pkg::MOD_LCTRL] = 1'b0;
			kbdtr_pkg::KEY_LALT: mods_next[kbdtr_pkg::MOD_LALT] = 1'b1;
			kbdtr_pkg::KEY_LALT | kbdtr_pkg::KEY_RELEASE:
				mods_next[kbdtr_pkg::MOD_LALT] = 1'b0;
			kbdtr_pkg::KEY_RALT: mods_next[kbdtr_pkg::MOD_RALT] = 1'b1;
			kbdtr_pkg::KEY_RALT | kbdtr_pkg::KEY_RELEASE:
				mods_next[kbdtr_pkg::MOD_RALT] = 1'b0;
			kbdtr_pkg::KEY_ESC:         char_o = kbdtr_pkg::CH_ESC;
			kbdtr_pkg::KEY_INS:         char_o = kbdtr_pkg::CH_INS;
			kbdtr_pkg::KEY_DEL:         char_o = kbdtr_pkg::CH_DEL;
			kbdtr_pkg::KEY_ARROW_LEFT:  char_o = kbdtr_pkg::CH_LEFT;
			kbdtr_pkg::KEY_POS1:        char_o = kbdtr_pkg::CH_HOME;
			kbdtr_pkg::KEY_END:         char_o = kbdtr_pkg::CH_END;
			kbdtr_pkg::KEY_ARROW_UP:    char_o = kbdtr_pkg::CH_UP;
			kbdtr_pkg::KEY_ARROW_DOWN:  char_o = kbdtr_pkg::CH_DOWN;
			kbdtr_pkg::KEY_PGUP:        char_o = kbdtr_pkg::CH_PGUP;
			kbdtr_pkg::KEY_PGDN:        char_o = kbdtr_pkg::CH_PGDN;
			kbdtr_pkg::KEY_ARROW_RIGHT: char_o = kbdtr_pkg::CH_RIGHT;
			kbdtr_pkg::KEY_MOUSE_L:     char_o = kbdtr_pkg::CH_MOUSE_L;
			kbdtr_pkg::KEY_MOUSE_R:     char_o = kbdtr_pkg::CH_MOUSE_R;
			default: begin
				if (code[7]) begin
					char_o = kbdtr_pkg::CH_NONE;
				end else if (code[15:4] == 12'h007) begin
					// Function keys F1 upwards land at 0x80.
					char_o = {4'h8, code[3:0]};
				end else if (code[15:6] != 10'd0) begin
					char_o = kbdtr_pkg::CH_NONE;
				end else if (mods[kbdtr_pkg::MOD_LALT] | mods[kbdtr_pkg::MOD_RALT]) begin
					char_o = kbdtr_pkg::alt_symbol(code[5:0]);
				end else if (mods[kbdtr_pkg::MOD_LCTRL]) begin
					// Ctrl ignores shift and folds letters onto 1 to 26.
					char_o = letter ? plain_c - 8'h60 : plain_c;
				end else begin
					char_o = rom_c;
				end
			end
		endcase
	end

endmodule

// File: rtl/core/keyboard_code_to_char_translator_unit.sv
// Top level of the keyboard code to character translator: input and
// result registers around kbdtr_xlate. Uses kbdtr_pkg.
`timescale 1ns / 1ps

// Usage
// key_code_in is taken with in_valid/in_stall; each item gives exactly one
// result item, char_out with the modifier bits after it, on out_valid/
// out_stall. A char_out of zero means the key produced no character.
// The item is first held in an input register, translated by a short
// table lookup, and written to the result register together with the
// modifier state. A result is offered once its item has passed the input
// register and reached the result register; one item is accepted every
// cycle while the output flows. When out_stall is high the result register
// holds; the input register then fills and in_stall rises in the same cycle
// that the input register cannot move on, so no item is lost or repeated.
// Reset clears both valid flags and the modifier state register; the block
// is ready for items in the first cycle after reset is released.

module keyboard_code_to_char_translator_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  kbdtr_pkg::code_t key_code_in,
	output logic             out_valid,
	input  logic             out_stall,
	output kbdtr_pkg::char_t char_out,
	output kbdtr_pkg::mod_t  modifiers
);

	logic             valid_s1;
	kbdtr_pkg::code_t code_s1;
	logic             valid_s2;
	kbdtr_pkg::char_t char_s2;
	kbdtr_pkg::mod_t  mods_s2;
	kbdtr_pkg::mod_t  mods_q;
	kbdtr_pkg::char_t char_c;
	kbdtr_pkg::mod_t  mods_c;
	logic             adv_s1;

	// The first stage moves on when the result register is empty or is
	// being emptied in this cycle.
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	kbdtr_xlate u_xlate (
		.code      (code_s1),
		.mods      (mods_q),
		.char_o    (char_c),
		.mods_next (mods_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mods_q   <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				mods_q   <= mods_c;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			code_s1 <= key_code_in;
		end
		if (adv_s1) begin
			char_s2 <= char_c;
			mods_s2 <= mods_c;
		end
	end

	assign out_valid = valid_s2;
	assign char_out  = char_s2;
	assign modifiers = mods_s2;

endmodule
